@@ hdl/ipp_pkg.sv @@
package ipp_pkg;

  localparam int GROUP_SIZE = 8;
  localparam int IDX_W      = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int CNT_W      = $clog2(GROUP_SIZE + 1);

  // fixed field widths
  localparam int ENTRY_W = 4;
  localparam int SHOWN_W = 3;
  localparam int CFG_W   = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(8);

  // register index taken from the byte address
  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  // scan token and what it has collected so far
  typedef struct packed {
    logic             tok;
    logic             past;      // target cell already passed
    logic             blk;       // visible or waiting entry above the target
    logic             tw;        // target was waiting
    logic             fw_found;  // first waiting entry below the target
    logic [IDX_W-1:0] fw_idx;
    logic             anyv;      // some other entry visible
    logic [IDX_W-1:0] pos;       // index of the cell receiving this carry
  } carry_t;

  // update broadcast to the cells at the end of a scan
  typedef struct packed {
    logic commit;
    logic on;
    logic blk;
    logic tw;
  } cmd_t;

endpackage

@@ hdl/ipp_cell.sv @@
module ipp_cell
  import ipp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   tgt_i,
  input  logic   fw_i,
  input  cmd_t   cmd_i,
  input  carry_t carry_i,
  output carry_t carry_o
);

  logic   vis_q, vis_d;
  logic   wait_q, wait_d;
  carry_t carry_q, carry_d;

  always_comb begin
    carry_d = '0;
    if (carry_i.tok && en_i) begin
      carry_d      = carry_i;
      carry_d.blk  = carry_i.blk | (!carry_i.past & !tgt_i & (vis_q | wait_q));
      carry_d.tw   = carry_i.tw | (tgt_i & wait_q);
      carry_d.anyv = carry_i.anyv | (!tgt_i & vis_q);
      carry_d.past = carry_i.past | tgt_i;
      if (carry_i.past && !carry_i.fw_found && wait_q) begin
        carry_d.fw_found = 1'b1;
        carry_d.fw_idx   = carry_i.pos;
      end
      carry_d.pos = carry_i.pos + IDX_W'(1);
    end
  end

  always_comb begin
    vis_d  = vis_q;
    wait_d = wait_q;
    if (cmd_i.commit && tgt_i) begin
      if (cmd_i.on) begin
        wait_d = cmd_i.blk;
        vis_d  = !cmd_i.blk;
      end else begin
        wait_d = 1'b0;
        vis_d  = 1'b0;
      end
    end else if (cmd_i.commit && fw_i && !cmd_i.on && !cmd_i.tw) begin
      wait_d = 1'b0;
      vis_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q   <= 1'b0;
      wait_q  <= 1'b0;
      carry_q <= '0;
    end else begin
      vis_q   <= vis_d;
      wait_q  <= wait_d;
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;

endmodule

@@ hdl/indicator_priority_preemption.sv @@
// Arbitrates one shared icon slot among up to GROUP_SIZE indicators, index 0
// highest priority. Each indicator's visible/waiting flags live in a cell of a
// chain; an event sends a token down the chain, one cell per cycle, and the
// flags are updated when the result is loaded, after the token reaches the
// last entry in use. The next event waits until the token has passed the
// entries in use (entries_in_use saturated to GROUP_SIZE) and the result is
// loaded; an out-of-range index is flagged. Exactly one result is returned per
// event; the result sits in an output register, so the next event can enter
// while it waits. entries_in_use is at byte address 0, reset value 8.
module indicator_priority_preemption
  import ipp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // events
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ENTRY_W-1:0] entry_index_i,
  input  logic               turn_on_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               slot_updated_o,
  output logic [SHOWN_W-1:0] shown_index_o,
  output logic               shown_visible_o,
  output logic               bad_index_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CFG_W-1:0]   cfg_q;
  logic [CNT_W-1:0]   eff_cnt;
  logic [IDX_W-1:0]   tap_idx;
  logic [ENTRY_W-1:0] idx_q;
  logic [ENTRY_W-1:0] tgt_idx;
  logic               on_q;
  carry_t             fin_q, fin_d;
  logic               fin_bad_q, fin_bad_d;
  logic               accept, bad, start, load;
  cmd_t               cmd;
  carry_t             inject;
  carry_t             chain [GROUP_SIZE];
  logic [GROUP_SIZE-1:0] en, tgt, fw_sel;

  logic               out_valid_q;
  logic               upd_q, upd_d;
  logic [SHOWN_W-1:0] shown_q, shown_d;
  logic               vis_q, vis_d;
  logic               bad_q, bad_d;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? DATA_W'(cfg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ENTRIES_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRIES_IN_USE) begin
      cfg_q <= pwdata[CFG_W-1:0];
    end
  end

  assign eff_cnt = (32'(cfg_q) > 32'(GROUP_SIZE)) ? CNT_W'(GROUP_SIZE) : CNT_W'(cfg_q);
  assign tap_idx = IDX_W'(eff_cnt - CNT_W'(1));

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign bad        = 32'(entry_index_i) >= 32'(eff_cnt);
  assign start      = accept && !bad;
  assign load       = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // the head cell sees the token in the accept cycle, before idx_q is loaded
  assign tgt_idx = accept ? entry_index_i : idx_q;

  always_comb begin
    inject     = '0;
    inject.tok = start;
  end

  assign cmd.commit = load && !fin_bad_q;
  assign cmd.on     = on_q;
  assign cmd.blk    = fin_q.blk;
  assign cmd.tw     = fin_q.tw;

  for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_cell
    assign en[k]     = k < int'(eff_cnt);
    assign tgt[k]    = 32'(tgt_idx) == k;
    assign fw_sel[k] = fin_q.fw_found && (32'(fin_q.fw_idx) == k);

    if (k == 0) begin : g_head
      ipp_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en[k]),
        .tgt_i   (tgt[k]),
        .fw_i    (fw_sel[k]),
        .cmd_i   (cmd),
        .carry_i (inject),
        .carry_o (chain[k])
      );
    end else begin : g_body
      ipp_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en[k]),
        .tgt_i   (tgt[k]),
        .fw_i    (fw_sel[k]),
        .cmd_i   (cmd),
        .carry_i (chain[k-1]),
        .carry_o (chain[k])
      );
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    fin_d     = fin_q;
    fin_bad_d = fin_bad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          fin_bad_d = bad;
          state_d   = bad ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[tap_idx].tok) begin
          fin_d   = chain[tap_idx];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result of the finished scan
  always_comb begin
    upd_d   = 1'b0;
    shown_d = '0;
    vis_d   = 1'b0;
    bad_d   = 1'b0;
    priority if (fin_bad_q) begin
      bad_d = 1'b1;
    end else if (on_q) begin
      if (!fin_q.blk) begin
        upd_d   = 1'b1;
        shown_d = SHOWN_W'(idx_q);
        vis_d   = 1'b1;
      end
    end else if (fin_q.tw) begin
      upd_d = 1'b0;
    end else if (fin_q.fw_found) begin
      upd_d   = 1'b1;
      shown_d = SHOWN_W'(fin_q.fw_idx);
      vis_d   = 1'b1;
    end else if (!fin_q.anyv) begin
      upd_d   = 1'b1;
      shown_d = SHOWN_W'(idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fin_q       <= '0;
      fin_bad_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fin_q     <= fin_d;
      fin_bad_q <= fin_bad_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= entry_index_i;
      on_q  <= turn_on_i;
    end
    if (load) begin
      upd_q   <= upd_d;
      shown_q <= shown_d;
      vis_q   <= vis_d;
      bad_q   <= bad_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_updated_o  = upd_q;
  assign shown_index_o   = shown_q;
  assign shown_visible_o = vis_q;
  assign bad_index_o     = bad_q;

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  import ipp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int NUM_PHASES      = 12;
  localparam int DRAIN_CYCLES    = 12;

  typedef struct packed {
    logic               updated;
    logic [SHOWN_W-1:0] index;
    logic               visible;
    logic               bad;
  } slot_result_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] index;
    logic               on;
    logic               typed;
    slot_result_t       want;
  } event_row_t;

  typedef enum int {SEND_SPARSE, RECV_SPARSE, NO_IDLE} idle_mode_e;

  localparam slot_result_t NO_CHANGE = '0;
  localparam slot_result_t BAD_EVENT = '{1'b0, 3'd0, 1'b0, 1'b1};

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ENTRY_W-1:0] entry_index_i;
  logic               turn_on_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               slot_updated_o;
  logic [SHOWN_W-1:0] shown_index_o;
  logic               shown_visible_o;
  logic               bad_index_o;

  // predictor state
  logic [GROUP_SIZE-1:0] shown_flags;
  logic [GROUP_SIZE-1:0] held_flags;
  logic [CFG_W-1:0]      cfg_entries;

  slot_result_t pending_slot_q[$];
  slot_result_t oldest_slot;
  int           errors;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_idle_pct;

  // directed events, starting from reset with all eight entries in use
  event_row_t directed_rows [0:22] = '{
    '{4'd0,  1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 1'b0}},  // off after reset hides slot
    '{4'd15, 1'b1, 1'b1, BAD_EVENT},
    '{4'd8,  1'b1, 1'b1, BAD_EVENT},
    '{4'd7,  1'b1, 1'b1, '{1'b1, 3'd7, 1'b1, 1'b0}},
    '{4'd3,  1'b1, 1'b0, NO_CHANGE},  // lower entry 7 stays visible
    '{4'd5,  1'b1, 1'b0, NO_CHANGE},  // preempted by 3
    '{4'd3,  1'b1, 1'b0, NO_CHANGE},  // on again
    '{4'd3,  1'b0, 1'b0, NO_CHANGE},  // hands slot to 5
    '{4'd0,  1'b1, 1'b0, NO_CHANGE},
    '{4'd2,  1'b1, 1'b0, NO_CHANGE},
    '{4'd2,  1'b0, 1'b0, NO_CHANGE},  // off while waiting
    '{4'd0,  1'b0, 1'b0, NO_CHANGE},
    '{4'd5,  1'b0, 1'b0, NO_CHANGE},
    '{4'd7,  1'b0, 1'b0, NO_CHANGE},
    '{4'd6,  1'b1, 1'b0, NO_CHANGE},
    '{4'd1,  1'b1, 1'b0, NO_CHANGE},
    '{4'd4,  1'b1, 1'b0, NO_CHANGE},
    '{4'd6,  1'b1, 1'b0, NO_CHANGE},  // visible entry demoted to waiting
    '{4'd1,  1'b0, 1'b0, NO_CHANGE},
    '{4'd10, 1'b0, 1'b1, BAD_EVENT},
    '{4'd4,  1'b0, 1'b0, NO_CHANGE},
    '{4'd6,  1'b0, 1'b0, NO_CHANGE},
    '{4'd9,  1'b1, 1'b1, BAD_EVENT}
  };

  int phase_entries [NUM_PHASES] = '{1, 8, 15, 0, 4, 2, 6, 8, 12, 3, 7, 5};

  indicator_priority_preemption dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .entry_index_i   (entry_index_i),
    .turn_on_i       (turn_on_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .slot_updated_o  (slot_updated_o),
    .shown_index_o   (shown_index_o),
    .shown_visible_o (shown_visible_o),
    .bad_index_o     (bad_index_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int entries_active();
    return (int'(cfg_entries) > GROUP_SIZE) ? GROUP_SIZE : int'(cfg_entries);
  endfunction

  // Slot arbitration for one event; updates the predictor flags.
  function automatic slot_result_t arbitrate_slot(input logic [ENTRY_W-1:0] idx,
                                                  input logic on);
    slot_result_t r;
    int n;
    int k;
    r = '0;
    n = entries_active();
    if (int'(idx) >= n) begin
      r.bad = 1'b1;
      return r;
    end
    if (on) begin
      for (k = 0; k < int'(idx); k++) begin
        if (shown_flags[k] || held_flags[k]) begin
          held_flags[idx]  = 1'b1;
          shown_flags[idx] = 1'b0;
          return r;
        end
      end
      held_flags[idx]  = 1'b0;
      shown_flags[idx] = 1'b1;
      r.updated = 1'b1;
      r.index   = idx[SHOWN_W-1:0];
      r.visible = 1'b1;
      return r;
    end
    shown_flags[idx] = 1'b0;
    if (held_flags[idx]) begin
      held_flags[idx] = 1'b0;
      return r;
    end
    for (k = int'(idx) + 1; k < n; k++) begin
      if (held_flags[k]) begin
        held_flags[k]  = 1'b0;
        shown_flags[k] = 1'b1;
        r.updated = 1'b1;
        r.index   = SHOWN_W'(k);
        r.visible = 1'b1;
        return r;
      end
    end
    for (k = 0; k < n; k++) begin
      if (shown_flags[k]) return r;
    end
    r.updated = 1'b1;
    r.index   = idx[SHOWN_W-1:0];
    return r;
  endfunction

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      SEND_SPARSE: begin
        send_idle_pct = 23;
        recv_idle_pct = 79;
      end
      RECV_SPARSE: begin
        send_idle_pct = 79;
        recv_idle_pct = 23;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_event(input logic [ENTRY_W-1:0] idx, input logic on,
                            input logic typed, input slot_result_t want);
    slot_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    entry_index_i <= idx;
    turn_on_i     <= on;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = arbitrate_slot(idx, on);
    pending_slot_q.push_back(typed ? want : r);
  endtask

  // stop sending and let every outstanding transaction drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_slot_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entries(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({REG_ENTRIES_IN_USE, 2'b00});
    pwdata  <= DATA_W'(value[CFG_W-1:0]);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_entries = value[CFG_W-1:0];
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result side: compare and drive random stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_slot_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual upd=%0d idx=%0d vis=%0d bad=%0d",
                 $time, slot_updated_o, shown_index_o, shown_visible_o, bad_index_o);
      end else begin
        oldest_slot = pending_slot_q.pop_front();
        check_field("slot_updated", oldest_slot.updated, slot_updated_o);
        check_field("shown_index", oldest_slot.index, shown_index_o);
        check_field("shown_visible", oldest_slot.visible, shown_visible_o);
        check_field("bad_index", oldest_slot.bad, bad_index_o);
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int n;
    logic [ENTRY_W-1:0] idx;
    logic on;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    entry_index_i = '0;
    turn_on_i     = 1'b0;
    out_stall_i   = 1'b0;
    errors        = 0;
    cycle_count   = 0;
    shown_flags   = '0;
    held_flags    = '0;
    cfg_entries   = ENTRIES_RESET;
    set_idle_mode(SEND_SPARSE);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_event(directed_rows[i].index, directed_rows[i].on,
                 directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_entries(phase_entries[p]);
      set_idle_mode(idle_mode_e'(p * 3 / NUM_PHASES));
      n = entries_active();
      repeat (ITEMS_PER_PHASE) begin
        // mostly in-range events so entries pile up; some out-of-range noise
        if (n > 0 && $urandom_range(99) < 88)
          idx = ENTRY_W'($urandom_range(n - 1, 0));
        else
          idx = ENTRY_W'($urandom_range(15, 0));
        on = ($urandom_range(99) < 60);
        send_event(idx, on, 1'b0, NO_CHANGE);
      end
    end

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ indicator_priority_preemption.f @@
hdl/ipp_pkg.sv
hdl/ipp_cell.sv
hdl/indicator_priority_preemption.sv
bench/tb_top.sv
